@@ hdl/tube_ipr_pkg.sv @@
`default_nettype none

package tube_ipr_pkg;

  localparam int CH1_FIFO_DEPTH_DEFAULT = 24;
  localparam int CH3_FIFO_DEPTH_DEFAULT = 2;

  localparam logic [7:0] STATUS_DATA_WAITING = 8'h80;
  localparam logic [7:0] STATUS_SPACE_FREE   = 8'h40;

  typedef enum logic [1:0] {
    OP_HOST_READ      = 2'd0,
    OP_HOST_WRITE     = 2'd1,
    OP_PARASITE_READ  = 2'd2,
    OP_PARASITE_WRITE = 2'd3
  } op_t;

  localparam logic DIR_TO_PARASITE = 1'b0;
  localparam logic DIR_TO_HOST     = 1'b1;

  localparam logic [1:0] CH_ONE   = 2'd0;
  localparam logic [1:0] CH_THREE = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } store_ctl_t;

  typedef struct packed {
    logic has_data;
    logic has_space;
  } store_stat_t;

endpackage

`default_nettype wire

@@ hdl/tube_ipr_fifo.sv @@
`default_nettype none

module tube_ipr_fifo
  import tube_ipr_pkg::*;
#(
  parameter int DEPTH = CH3_FIFO_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire store_ctl_t  ctl,
  input  wire logic [7:0]  wdata,
  output logic [7:0]       rdata,
  output store_stat_t      stat
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [7:0]       mem [DEPTH];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] tail_wrap;
  logic [IDX_W-1:0] tail;

  always_comb begin
    tail_sum  = SUM_W'(head) + SUM_W'(count);
    tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? (tail_sum - SUM_W'(DEPTH)) : tail_sum;
    tail      = tail_wrap[IDX_W-1:0];
    head_next = (head == IDX_W'(DEPTH - 1)) ? '0 : (head + IDX_W'(1));
  end

  assign rdata          = mem[head];
  assign stat.has_data  = (count != '0);
  assign stat.has_space = (count < CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.push && stat.has_space) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop && stat.has_data) begin
      head  <= head_next;
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && stat.has_space) begin
      mem[tail] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tube_ipr_latch.sv @@
`default_nettype none

module tube_ipr_latch
  import tube_ipr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire store_ctl_t  ctl,
  input  wire logic [7:0]  wdata,
  output logic [7:0]       rdata,
  output store_stat_t      stat
);

  logic [7:0] data;
  logic       full;

  assign rdata          = data;
  assign stat.has_data  = full;
  assign stat.has_space = !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (ctl.push) begin
      full <= 1'b1;
    end else if (ctl.pop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tube_interprocessor_registers_unit.sv @@
`default_nettype none
// An accepted input transaction is first registered as the access, then applied to the
// stores in the same cycle as its result is registered.
// Throughput: one access per cycle, held back only while a result waits on out_ready.
// Reset: synchronous rst empties every latch and FIFO and clears both pipeline stages;
// FIFO contents are not cleared, as the fill counts keep stale entries from being read.
module tube_interprocessor_registers_unit
  import tube_ipr_pkg::*;
#(
  parameter int CH1_FIFO_DEPTH = CH1_FIFO_DEPTH_DEFAULT,
  parameter int CH3_FIFO_DEPTH = CH3_FIFO_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] operation,
  input  wire logic [2:0] register_index,
  input  wire logic [7:0] write_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_data,
  output logic            accepted
);

  logic        acc_valid;
  op_t         acc_op;
  logic [2:0]  acc_index;
  logic [7:0]  acc_wdata;

  logic        advance;
  logic        fire;

  store_ctl_t  st_ctl  [4][2];
  store_stat_t st_stat [4][2];
  logic [7:0]  st_byte [4][2];

  logic [1:0]  ch;
  logic        is_data;
  logic        parasite;
  logic        is_write;
  logic        dir_me;
  logic        dir_other;
  logic        other_is_fifo;
  logic [7:0]  read_data_next;
  logic        accepted_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !acc_valid || advance;
  assign fire     = acc_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (in_ready) begin
      acc_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_op    <= op_t'(operation);
      acc_index <= register_index;
      acc_wdata <= write_data;
    end
  end

  always_comb begin
    ch            = acc_index[2:1];
    is_data       = acc_index[0];
    parasite      = (acc_op == OP_PARASITE_READ) || (acc_op == OP_PARASITE_WRITE);
    is_write      = (acc_op == OP_HOST_WRITE) || (acc_op == OP_PARASITE_WRITE);
    dir_me        = parasite ? DIR_TO_PARASITE : DIR_TO_HOST;
    dir_other     = parasite ? DIR_TO_HOST : DIR_TO_PARASITE;
    other_is_fifo = (ch == CH_THREE) || ((ch == CH_ONE) && (dir_other == DIR_TO_HOST));

    read_data_next = 8'h00;
    accepted_next  = 1'b0;
    for (int c = 0; c < 4; c++) begin
      for (int d = 0; d < 2; d++) begin
        st_ctl[c][d] = '0;
      end
    end

    if (!is_write) begin
      if (is_data) begin
        if (st_stat[ch][dir_me].has_data) begin
          read_data_next          = st_byte[ch][dir_me];
          accepted_next           = 1'b1;
          st_ctl[ch][dir_me].pop  = fire;
        end
      end else begin
        if (st_stat[ch][dir_me].has_data) begin
          read_data_next = read_data_next | STATUS_DATA_WAITING;
        end
        if (st_stat[ch][dir_other].has_space) begin
          read_data_next = read_data_next | STATUS_SPACE_FREE;
        end
        accepted_next = 1'b1;
      end
    end else if (is_data) begin
      if (st_stat[ch][dir_other].has_space || (parasite && !other_is_fifo)) begin
        accepted_next              = 1'b1;
        st_ctl[ch][dir_other].push = fire;
      end
    end
  end

  tube_ipr_latch u_ch1_to_parasite (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[0][0]),
    .wdata (acc_wdata),
    .rdata (st_byte[0][0]),
    .stat  (st_stat[0][0])
  );

  tube_ipr_fifo #(
    .DEPTH (CH1_FIFO_DEPTH)
  ) u_ch1_to_host (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[0][1]),
    .wdata (acc_wdata),
    .rdata (st_byte[0][1]),
    .stat  (st_stat[0][1])
  );

  tube_ipr_latch u_ch2_to_parasite (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[1][0]),
    .wdata (acc_wdata),
    .rdata (st_byte[1][0]),
    .stat  (st_stat[1][0])
  );

  tube_ipr_latch u_ch2_to_host (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[1][1]),
    .wdata (acc_wdata),
    .rdata (st_byte[1][1]),
    .stat  (st_stat[1][1])
  );

  tube_ipr_fifo #(
    .DEPTH (CH3_FIFO_DEPTH)
  ) u_ch3_to_parasite (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[2][0]),
    .wdata (acc_wdata),
    .rdata (st_byte[2][0]),
    .stat  (st_stat[2][0])
  );

  tube_ipr_fifo #(
    .DEPTH (CH3_FIFO_DEPTH)
  ) u_ch3_to_host (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[2][1]),
    .wdata (acc_wdata),
    .rdata (st_byte[2][1]),
    .stat  (st_stat[2][1])
  );

  tube_ipr_latch u_ch4_to_parasite (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[3][0]),
    .wdata (acc_wdata),
    .rdata (st_byte[3][0]),
    .stat  (st_stat[3][0])
  );

  tube_ipr_latch u_ch4_to_host (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl[3][1]),
    .wdata (acc_wdata),
    .rdata (st_byte[3][1]),
    .stat  (st_stat[3][1])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data <= read_data_next;
      accepted  <= accepted_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tube_ipr_checker.sv @@
`default_nettype none

module tube_ipr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] operation,
  input wire logic [2:0] register_index,
  input wire logic [7:0] write_data,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic       accepted
);

  // A result held back by the consumer must not change.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(accepted))
    else $error("Result transaction changed while stalled.");

  // Any non-zero byte comes from a status read or a successful pop.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != 8'h00) |-> accepted)
    else $error("Non-zero read data reported on a refused access.");

  // The input side only stalls when both stages are occupied.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled while the result stage could advance.");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid straight after reset.");

  // The whole input payload, so that one stability check covers every field.
  logic [12:0] in_payload;
  assign in_payload = {operation, register_index, write_data};

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> $stable(in_payload) || !in_valid)
    else $error("Input payload changed while stalled.");

endmodule

bind tube_interprocessor_registers_unit tube_ipr_checker u_checker (.*);

`default_nettype wire
